FILE: rtl/core/tgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tgc_pkg;

   // Width of the saturating age counters.
   localparam int TIMER_BITS = 16;
   // Width of the timing registers.
   localparam int CFG_BITS   = 16;
   // Compares run at the wider of the two.
   localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 8;
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = CFG_BITS'(50);
   localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(1000);
   localparam logic [CFG_BITS-1:0] CLICK_GAP_RESET  = CFG_BITS'(280);
   localparam logic [CFG_BITS-1:0] MIN_PRESS_RESET  = CFG_BITS'(50);
   localparam logic                ACTIVE_RESET     = 1'b1;

   localparam logic [1:0] CLICK_NONE   = 2'd0;
   localparam logic [1:0] CLICK_TRIPLE = 2'd3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_DEBOUNCE   = 3'd0,
      REG_LONG_PRESS = 3'd1,
      REG_CLICK_GAP  = 3'd2,
      REG_MIN_PRESS  = 3'd3,
      REG_ACTIVE     = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_ms;
      logic [CFG_BITS-1:0] long_press_ms;
      logic [CFG_BITS-1:0] click_gap_ms;
      logic [CFG_BITS-1:0] min_press_ms;
      logic                active_level;
   } cfg_type;

   typedef struct packed {
      logic                  prev_raw;
      logic                  stable_level;
      logic [TIMER_BITS-1:0] since_change;
      logic [TIMER_BITS-1:0] press_age;
      logic                  long_done;
      logic [1:0]            click_tally;
      logic [TIMER_BITS-1:0] release_age;
   } state_type;

   typedef struct packed {
      logic [1:0] click_event;
      logic       long_press;
      logic       pressed;
   } result_type;

   function automatic logic [TIMER_BITS-1:0] age_advance(input logic [TIMER_BITS-1:0] v);
      logic [TIMER_BITS-1:0] r;
      r = (v == '1) ? v : v + 1'b1;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tgc_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module tgc_csr
   import tgc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    wr_en,
   input  wire logic [CSR_IDX_BITS-1:0] wr_index,
   input  wire logic [CFG_BITS-1:0]     wr_data,
   output cfg_type                      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index_type'(wr_index))
            REG_DEBOUNCE:   cfg_in.debounce_ms   = wr_data;
            REG_LONG_PRESS: cfg_in.long_press_ms = wr_data;
            REG_CLICK_GAP:  cfg_in.click_gap_ms  = wr_data;
            REG_MIN_PRESS:  cfg_in.min_press_ms  = wr_data;
            REG_ACTIVE:     cfg_in.active_level  = wr_data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
         cfg_ff.click_gap_ms  <= CLICK_GAP_RESET;
         cfg_ff.min_press_ms  <= MIN_PRESS_RESET;
         cfg_ff.active_level  <= ACTIVE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tgc_step.sv
`timescale 1ns / 1ps
`default_nettype none

module tgc_step
   import tgc_pkg::*;
(
   input  wire cfg_type   cfg,
   input  wire state_type cur,
   input  wire logic      raw_level,
   output state_type      nxt,
   output result_type     res
);

   always_comb begin
      logic       touched;
      logic       settled;
      logic       in_window;
      logic [1:0] evt;
      logic       longp;

      nxt              = cur;
      nxt.since_change = age_advance(cur.since_change);
      nxt.press_age    = age_advance(cur.press_age);
      nxt.release_age  = age_advance(cur.release_age);

      // Restart the stability timer on any raw edge.
      if (raw_level != cur.prev_raw)
         nxt.since_change = '0;

      settled   = CMP_BITS'(nxt.since_change) > CMP_BITS'(cfg.debounce_ms);
      in_window = (CMP_BITS'(nxt.press_age) > CMP_BITS'(cfg.min_press_ms)) &&
                  (CMP_BITS'(nxt.press_age) < CMP_BITS'(cfg.long_press_ms));

      if (settled && (raw_level != cur.stable_level)) begin
         nxt.stable_level = raw_level;
         if (raw_level == cfg.active_level) begin
            nxt.press_age = '0;
            nxt.long_done = 1'b0;
         end else if (!cur.long_done && in_window) begin
            if (cur.click_tally != CLICK_TRIPLE)
               nxt.click_tally = cur.click_tally + 2'd1;
            nxt.release_age = '0;
         end
      end

      // Report pending clicks once the gap has run out.
      evt = CLICK_NONE;
      if ((nxt.click_tally != CLICK_NONE) &&
          (CMP_BITS'(nxt.release_age) > CMP_BITS'(cfg.click_gap_ms))) begin
         evt             = nxt.click_tally;
         nxt.click_tally = CLICK_NONE;
      end

      touched = (nxt.stable_level == cfg.active_level);

      longp = 1'b0;
      if (touched && !nxt.long_done &&
          (CMP_BITS'(nxt.press_age) >= CMP_BITS'(cfg.long_press_ms))) begin
         nxt.long_done   = 1'b1;
         nxt.click_tally = CLICK_NONE;
         longp           = 1'b1;
      end

      nxt.prev_raw = raw_level;

      res.click_event = evt;
      res.long_press  = longp;
      res.pressed     = touched;
   end

endmodule

`default_nettype wire

FILE: rtl/core/touch_gesture_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Touch gesture classifier. Each request is one millisecond tick carrying the
// raw sampled touch level in req_tdata[0]; every request yields exactly one
// response. The level is debounced (it must stay unchanged for more than
// debounce_ms ticks), presses are timed, and releases of presses longer than
// min_press_ms and shorter than long_press_ms count as clicks. When more than
// click_gap_ms ticks pass after the last click, the response reports single,
// double or triple-or-more clicks; a press held for long_press_ms ticks reports
// a long press once and drops pending clicks. The block takes one request per
// clock cycle while the response channel is not stalled; each request passes the
// input register, then the state update that loads the response register, and
// the rate is set by that update of the timer and click state. Configuration
// registers (csr_index: 0 debounce_ms, 1 long_press_ms, 2 click_gap_ms,
// 3 min_press_ms, 4 active_level) are always ready and are to be written only
// while no request is in flight.

module touch_gesture_classifier
   import tgc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,  // [0] raw_level
   // response channel
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,  // [1:0] click_event, [2] long_press,
                                                     // [3] pressed
   // configuration write channel
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CFG_BITS-1:0]      csr_wdata
);

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   result_type res;
   result_type rsp_ff;

   logic in_valid_ff;
   logic in_raw_ff;
   logic rsp_valid_ff;
   logic advance;
   logic accept;

   // Configuration writes complete at once.
   assign csr_ready = 1'b1;

   tgc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // Advance the held request into the response register when that register
   // is empty or being drained this cycle.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // Input register payload: hold while stalled.
   always_ff @(posedge clock) begin
      if (accept)
         in_raw_ff <= req_tdata[0];
   end

   tgc_step u_step (
      .cfg       (cfg),
      .cur       (state_ff),
      .raw_level (in_raw_ff),
      .nxt       (state_in),
      .res       (res)
   );

   // Tick state: released level is low, debounce timer starts saturated.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.prev_raw     <= 1'b0;
         state_ff.stable_level <= 1'b0;
         state_ff.since_change <= '1;
         state_ff.press_age    <= '0;
         state_ff.long_done    <= 1'b0;
         state_ff.click_tally  <= CLICK_NONE;
         state_ff.release_age  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance)
         rsp_ff <= res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - 4){1'b0}}, rsp_ff.pressed, rsp_ff.long_press,
                        rsp_ff.click_event};

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tgc_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 4;    // two internal stages plus margin
   localparam int HOLD_OFF_CYCLES = 80;   // far longer than the block can buffer
   localparam int WATCHDOG_CYCLES = 1000; // quiet cycles before giving up

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // [0] raw_level
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // [1:0] click_event, [2] long_press, [3] pressed
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CFG_BITS-1:0]      csr_wdata;

   touch_gesture_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Gesture tracker mirrored in the bench: timing registers and tap state.
   cfg_type               timing_cfg;
   logic                  raw_last;
   logic                  level_held;
   logic [TIMER_BITS-1:0] steady_age;
   logic [TIMER_BITS-1:0] hold_age;
   logic                  long_flagged;
   logic [1:0]            clicks_pending;
   logic [TIMER_BITS-1:0] gap_age;

   // One entry per accepted tick request, oldest first.
   result_type tick_results_due[$];

   int  fault_count = 0;
   int  ticks_sent  = 0;
   bit  pacing_on   = 1'b1;   // random gaps on both sides when set
   int  sink_hold   = 0;      // one-shot long hold-off for the response side

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Tap tracker
   // ------------------------------------------------------------------

   function automatic logic [TIMER_BITS-1:0] bump_age(input logic [TIMER_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic int clip(input int v, input int ceiling);
      return (v > ceiling) ? ceiling : v;
   endfunction

   function automatic cfg_type make_cfg(input int deb, input int lng, input int gap,
                                        input int mn, input logic act);
      cfg_type c;
      c.debounce_ms   = CFG_BITS'(deb);
      c.long_press_ms = CFG_BITS'(lng);
      c.click_gap_ms  = CFG_BITS'(gap);
      c.min_press_ms  = CFG_BITS'(mn);
      c.active_level  = act;
      return c;
   endfunction

   task automatic clear_tracker();
      timing_cfg     = make_cfg(DEBOUNCE_RESET, LONG_PRESS_RESET, CLICK_GAP_RESET,
                                MIN_PRESS_RESET, ACTIVE_RESET);
      raw_last       = ~ACTIVE_RESET;
      level_held     = ~ACTIVE_RESET;
      steady_age     = '1;
      hold_age       = '0;
      long_flagged   = 1'b0;
      clicks_pending = CLICK_NONE;
      gap_age        = '0;
   endtask

   // Advance the tracker by one millisecond tick and return what it reports.
   function automatic result_type predict_tick(input logic raw);
      result_type r;
      r = '0;
      steady_age = bump_age(steady_age);
      hold_age   = bump_age(hold_age);
      gap_age    = bump_age(gap_age);
      if (raw != raw_last) begin
         steady_age = '0;
      end
      // Debounced edge: a press restarts the press timer, a release of a
      // press of click length bumps the tally and restarts the gap timer.
      if (steady_age > timing_cfg.debounce_ms && raw != level_held) begin
         level_held = raw;
         if (level_held == timing_cfg.active_level) begin
            hold_age     = '0;
            long_flagged = 1'b0;
         end else if (!long_flagged && hold_age > timing_cfg.min_press_ms
                      && hold_age < timing_cfg.long_press_ms) begin
            if (clicks_pending != CLICK_TRIPLE) begin
               clicks_pending = clicks_pending + 2'd1;
            end
            gap_age = '0;
         end
      end
      if (clicks_pending != CLICK_NONE && gap_age > timing_cfg.click_gap_ms) begin
         r.click_event  = clicks_pending;
         clicks_pending = CLICK_NONE;
      end
      // A held press fires once and throws away the pending clicks.
      if (level_held == timing_cfg.active_level && !long_flagged
          && hold_age >= timing_cfg.long_press_ms) begin
         long_flagged   = 1'b1;
         clicks_pending = CLICK_NONE;
         r.long_press   = 1'b1;
      end
      raw_last  = raw;
      r.pressed = (level_held == timing_cfg.active_level);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one tick request; return at the accepting edge with valid still
   // high, so that the next call can keep it high without a glitch.
   task automatic send_tick(input logic raw);
      int gap;
      gap = pacing_on ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(raw);
      do @(posedge clock); while (req_tready !== 1'b1);
      tick_results_due.push_back(predict_tick(raw));
      ticks_sent++;
   endtask

   task automatic send_run(input logic raw, input int count);
      repeat (count) send_tick(raw);
   endtask

   // Drop the request and hold until every pending response is back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         REG_DEBOUNCE:   timing_cfg.debounce_ms   = value;
         REG_LONG_PRESS: timing_cfg.long_press_ms = value;
         REG_CLICK_GAP:  timing_cfg.click_gap_ms  = value;
         REG_MIN_PRESS:  timing_cfg.min_press_ms  = value;
         REG_ACTIVE:     timing_cfg.active_level  = value[0];
         default: ;
      endcase
   endtask

   // Registers change only with the pipeline empty.
   task automatic apply_settings(input cfg_type c);
      wait_drained();
      write_register(REG_DEBOUNCE,   c.debounce_ms);
      write_register(REG_LONG_PRESS, c.long_press_ms);
      write_register(REG_CLICK_GAP,  c.click_gap_ms);
      write_register(REG_MIN_PRESS,  c.min_press_ms);
      write_register(REG_ACTIVE,     CFG_BITS'(c.active_level));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One well-formed touch: optional chatter, a press of chosen length,
   // optional chatter on release, then a quiet stretch either inside the
   // click gap (to chain clicks) or past it (to get them reported).
   task automatic send_gesture();
      logic act;
      int   deb;
      int   lo;
      int   hi;
      int   hold;
      int   quiet;
      int   pick;
      act  = timing_cfg.active_level;
      deb  = clip(timing_cfg.debounce_ms, 40);
      lo   = int'(timing_cfg.min_press_ms) + 1;
      hi   = int'(timing_cfg.long_press_ms) - 1;
      pick = $urandom_range(0, 9);
      if (pick < 6 && lo <= hi) begin
         hold = $urandom_range(lo, clip(hi, lo + 60));
      end else if (pick < 9) begin
         hold = $urandom_range(1, clip(lo, 80));
      end else begin
         hold = clip(timing_cfg.long_press_ms, 1100) + $urandom_range(0, 3);
      end
      if (deb > 0 && $urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            send_run(act, $urandom_range(1, clip(deb, 6)));
            send_run(~act, 1);
         end
      end
      send_run(act, (hold > deb + 1) ? hold : deb + 2);
      if (deb > 0 && $urandom_range(0, 2) == 0) begin
         send_run(~act, $urandom_range(1, clip(deb, 6)));
         send_run(act, 1);
      end
      if ($urandom_range(0, 1) == 0) begin
         quiet = $urandom_range(0, clip(timing_cfg.click_gap_ms, 40));
      end else begin
         quiet = clip(timing_cfg.click_gap_ms, 300) + 1 + $urandom_range(0, 2);
      end
      send_run(~act, deb + 1 + quiet);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
   endtask

   task automatic run_phase(input cfg_type c, input int budget);
      int first;
      apply_settings(c);
      first = ticks_sent;
      while (ticks_sent - first < budget) begin
         pacing_on = ($urandom_range(0, 5) != 0);
         if ($urandom_range(0, 6) == 0) begin
            send_noise();
         end else begin
            send_gesture();
         end
      end
      pacing_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset timing: short touches are swallowed by the 50 tick debounce.
   task automatic test_reset_defaults();
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // Four quick clicks in a row: the tally saturates and reports triple.
   task automatic test_click_saturation();
      apply_settings(make_cfg(0, 20, 4, 0, 1'b1));
      repeat (4) begin
         send_run(1'b1, 2);
         send_run(1'b0, 2);
      end
      send_run(1'b0, 5);
   endtask

   // Zero long-press time: the press is long the tick it is taken.
   task automatic test_long_press_zero();
      apply_settings(make_cfg(0, 0, 1, 0, 1'b1));
      send_run(1'b1, 3);
      send_run(1'b0, 3);
   endtask

   // Flip the active level with the line idle: the held level becomes a press.
   task automatic test_active_flip();
      apply_settings(make_cfg(0, 3, 1, 0, 1'b0));
      send_run(1'b0, 3);
      send_run(1'b1, 2);
      send_tick(1'b0);
   endtask

   // Stall the response side while requests keep coming back to back.
   task automatic test_backpressure();
      int k;
      apply_settings(make_cfg(1, 6, 3, 1, 1'b1));
      pacing_on = 1'b0;
      sink_hold = HOLD_OFF_CYCLES;
      for (k = 0; k < 40; k++) begin
         send_tick(k[2]);
      end
      pacing_on = 1'b1;
   endtask

   task automatic test_random_gestures();
      run_phase(make_cfg(0, 1, 0, 0, 1'b1), 120);
      run_phase(make_cfg(2, 12, 6, 2, 1'b1), 200);
      run_phase(make_cfg(1, 20, 10, 3, 1'b0), 200);
      run_phase(make_cfg(3, 65535, 4, 1, 1'b1), 100);
      run_phase(make_cfg(1, 10, 65535, 0, 1'b0), 150);
      run_phase(make_cfg(65535, 5, 3, 65535, 1'b1), 40);
      run_phase(make_cfg(DEBOUNCE_RESET, LONG_PRESS_RESET, CLICK_GAP_RESET,
                         MIN_PRESS_RESET, ACTIVE_RESET), 600);
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Response ready: random stalls per response, plus the one long hold-off.
   initial begin : response_sink
      int stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (sink_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (sink_hold) @(negedge clock);
            sink_hold = 0;
         end
         stall = pacing_on ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   task automatic flag_field(input string field, input int want, input int got);
      fault_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
   endtask

   // Compare each accepted response with the oldest pending tick.
   initial begin : response_checker
      result_type want;
      result_type got;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            got.click_event = rsp_tdata[1:0];
            got.long_press  = rsp_tdata[2];
            got.pressed     = rsp_tdata[3];
            if (tick_results_due.size() == 0) begin
               fault_count++;
               $display("%0t: response with no tick pending, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               want = tick_results_due.pop_front();
               if (got.click_event !== want.click_event) begin
                  flag_field("click_event", want.click_event, got.click_event);
               end
               if (got.long_press !== want.long_press) begin
                  flag_field("long_press", want.long_press, got.long_press);
               end
               if (got.pressed !== want.pressed) begin
                  flag_field("pressed", want.pressed, got.pressed);
               end
            end
         end
      end
   end

   // Abort when no handshake of any kind happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1)
             || (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
             || (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("touch_gesture_classifier test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = REG_DEBOUNCE;
      csr_wdata  = '0;
      clear_tracker();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_click_saturation();
      test_long_press_zero();
      test_active_flip();
      test_backpressure();
      test_random_gestures();

      // Hold on past the last response to catch any stray extra one.
      wait_drained();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && tick_results_due.size() == 0) begin
         $display("touch_gesture_classifier test passed");
      end else begin
         $display("touch_gesture_classifier test failed");
      end
      $finish;
   end

endmodule
